// ----- rtl/i2cm_pkg.sv -----
`timescale 1ns / 1ps

package i2cm_pkg;

    localparam int PHASE_W     = 10;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int CFG_IDX_W   = 1;

    localparam logic [PHASE_W-1:0]   PHASE_TICKS_RESET = 10'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_TICKS   = 1'b0;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_ADDR_NACK = 2'd1;
    localparam logic [1:0] STATUS_DATA_NACK = 2'd2;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [4:0] {
        PH_IDLE      = 5'd0,
        PH_START     = 5'd1,
        PH_ADDR_LO   = 5'd2,
        PH_ADDR_HI   = 5'd3,
        PH_AACK_LO   = 5'd4,
        PH_AACK_HI   = 5'd5,
        PH_WR_LO     = 5'd6,
        PH_WR_HI     = 5'd7,
        PH_WACK_LO   = 5'd8,
        PH_WACK_HI   = 5'd9,
        PH_RD_LO     = 5'd10,
        PH_RD_HI     = 5'd11,
        PH_RACK_LO   = 5'd12,
        PH_RACK_HI   = 5'd13,
        PH_STOP_LO   = 5'd14,
        PH_STOP_HI   = 5'd15,
        PH_STOP_FREE = 5'd16
    } phase_t;

    typedef struct packed {
        logic [1:0] op;
        logic [6:0] device_address;
        logic [7:0] byte_count;
        logic [7:0] write_byte;
        logic       sda_in;
    } cmd_item_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [1:0] status;
        logic       byte_taken;
        logic [7:0] read_data;
        logic       read_valid;
    } rsp_item_t;

endpackage

// ----- rtl/i2cm_cmd_if.sv -----
`timescale 1ns / 1ps

interface i2cm_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [6:0] device_address;
    logic [7:0] byte_count;
    logic [7:0] write_byte;
    logic       sda_in;

    modport source (output valid, output op, output device_address, output byte_count,
                    output write_byte, output sda_in, input ready);
    modport sink (input valid, input op, input device_address, input byte_count,
                  input write_byte, input sda_in, output ready);
endinterface

// ----- rtl/i2cm_rsp_if.sv -----
`timescale 1ns / 1ps

interface i2cm_rsp_if;
    logic       valid;
    logic       ready;
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
    logic       byte_taken;
    logic [7:0] read_data;
    logic       read_valid;

    modport source (output valid, output scl_out, output sda_out, output busy_res,
                    output done_res, output status, output byte_taken, output read_data,
                    output read_valid, input ready);
    modport sink (input valid, input scl_out, input sda_out, input busy_res,
                  input done_res, input status, input byte_taken, input read_data,
                  input read_valid, output ready);
endinterface

// ----- rtl/i2cm_regs.sv -----
`timescale 1ns / 1ps

module i2cm_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [i2cm_pkg::PADDR_W-1:0]  paddr,
    input  logic [i2cm_pkg::PDATA_W-1:0]  pwdata,
    output logic [i2cm_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output logic [i2cm_pkg::PHASE_W-1:0]  phase_ticks
);
    import i2cm_pkg::*;

    logic [PHASE_W-1:0]   phase_ticks_reg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[PADDR_W-1:PADDR_W-CFG_IDX_W];
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg <= PHASE_TICKS_RESET;
        end
        else if (wr_en && reg_idx == REG_PHASE_TICKS)
        begin
            phase_ticks_reg <= pwdata[PHASE_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_PHASE_TICKS)
        begin
            prdata = {{(PDATA_W-PHASE_W){1'b0}}, phase_ticks_reg};
        end
    end

    assign phase_ticks = phase_ticks_reg;
endmodule

// ----- rtl/i2cm_seq.sv -----
`timescale 1ns / 1ps

module i2cm_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          enable,
    input  i2cm_pkg::cmd_item_t           cmd,
    input  logic [i2cm_pkg::PHASE_W-1:0]  phase_ticks,
    output i2cm_pkg::rsp_item_t           res
);
    import i2cm_pkg::*;

    phase_t             phase_reg, phase_next;
    logic [3:0]         bit_cnt_reg, bit_cnt_next;
    logic [7:0]         shift_reg, shift_next;
    logic [7:0]         bytes_rem_reg, bytes_rem_next;
    logic [PHASE_W-1:0] timer_reg, timer_next;
    logic               read_dir_reg, read_dir_next;
    logic [1:0]         outcome_reg, outcome_next;
    logic               scl_reg, scl_next;
    logic               sda_reg, sda_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            bit_cnt_reg   <= '0;
            shift_reg     <= '0;
            bytes_rem_reg <= '0;
            timer_reg     <= '0;
            read_dir_reg  <= 1'b0;
            outcome_reg   <= STATUS_OK;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
        end
        else if (enable)
        begin
            phase_reg     <= phase_next;
            bit_cnt_reg   <= bit_cnt_next;
            shift_reg     <= shift_next;
            bytes_rem_reg <= bytes_rem_next;
            timer_reg     <= timer_next;
            read_dir_reg  <= read_dir_next;
            outcome_reg   <= outcome_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
        end
    end

    always_comb
    begin
        logic [PHASE_W:0]   limit;
        logic [PHASE_W:0]   timer_inc;
        logic [3:0]         cnt_inc;
        logic [7:0]         bytes_dec;
        logic               done;
        logic               taken;
        logic               rvalid;
        logic [7:0]         rdata;

        limit     = (phase_ticks == '0) ? (PHASE_W+1)'(1) : {1'b0, phase_ticks};
        timer_inc = {1'b0, timer_reg} + (PHASE_W+1)'(1);
        cnt_inc   = bit_cnt_reg + 4'd1;
        bytes_dec = bytes_rem_reg - 8'd1;
        done      = 1'b0;
        taken     = 1'b0;
        rvalid    = 1'b0;
        rdata     = '0;

        phase_next     = phase_reg;
        bit_cnt_next   = bit_cnt_reg;
        shift_next     = shift_reg;
        bytes_rem_next = bytes_rem_reg;
        timer_next     = timer_reg;
        read_dir_next  = read_dir_reg;
        outcome_next   = outcome_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;

        if (phase_reg == PH_IDLE)
        begin
            if (cmd.op == OP_WRITE || cmd.op == OP_READ)
            begin
                read_dir_next  = (cmd.op == OP_READ);
                bytes_rem_next = cmd.byte_count;
                shift_next     = {cmd.device_address, (cmd.op == OP_READ)};
                bit_cnt_next   = '0;
                outcome_next   = STATUS_OK;
                timer_next     = '0;
                phase_next     = PH_START;
                scl_next       = 1'b1;
                sda_next       = 1'b0;
            end
        end
        else if (timer_inc < limit)
        begin
            timer_next = timer_inc[PHASE_W-1:0];
        end
        else
        begin
            timer_next = '0;
            case (phase_reg)
                PH_START:
                begin
                    bit_cnt_next = '0;
                    phase_next   = PH_ADDR_LO;
                    scl_next     = 1'b0;
                    sda_next     = shift_reg[7];
                end
                PH_ADDR_LO, PH_WR_LO:
                begin
                    phase_next = (phase_reg == PH_ADDR_LO) ? PH_ADDR_HI : PH_WR_HI;
                    scl_next   = 1'b1;
                    sda_next   = shift_reg[7];
                end
                PH_ADDR_HI, PH_WR_HI:
                begin
                    if (cnt_inc >= BITS_PER_BYTE)
                    begin
                        bit_cnt_next = '0;
                        phase_next   = (phase_reg == PH_ADDR_HI) ? PH_AACK_LO : PH_WACK_LO;
                        scl_next     = 1'b0;
                        sda_next     = 1'b1;
                    end
                    else
                    begin
                        bit_cnt_next = cnt_inc;
                        shift_next   = {shift_reg[6:0], 1'b0};
                        phase_next   = (phase_reg == PH_ADDR_HI) ? PH_ADDR_LO : PH_WR_LO;
                        scl_next     = 1'b0;
                        sda_next     = shift_reg[6];
                    end
                end
                PH_AACK_LO, PH_WACK_LO, PH_RD_LO:
                begin
                    case (phase_reg)
                        PH_AACK_LO: phase_next = PH_AACK_HI;
                        PH_WACK_LO: phase_next = PH_WACK_HI;
                        default:    phase_next = PH_RD_HI;
                    endcase
                    scl_next = 1'b1;
                    sda_next = 1'b1;
                end
                PH_AACK_HI, PH_WACK_HI:
                begin
                    if (cmd.sda_in)
                    begin
                        outcome_next = (phase_reg == PH_AACK_HI) ? STATUS_ADDR_NACK
                                                                 : STATUS_DATA_NACK;
                        phase_next   = PH_STOP_LO;
                        scl_next     = 1'b0;
                        sda_next     = 1'b0;
                    end
                    else if (bytes_rem_reg == '0)
                    begin
                        phase_next = PH_STOP_LO;
                        scl_next   = 1'b0;
                        sda_next   = 1'b0;
                    end
                    else if (read_dir_reg)
                    begin
                        shift_next   = '0;
                        bit_cnt_next = '0;
                        phase_next   = PH_RD_LO;
                        scl_next     = 1'b0;
                        sda_next     = 1'b1;
                    end
                    else
                    begin
                        shift_next     = cmd.write_byte;
                        taken          = 1'b1;
                        bit_cnt_next   = '0;
                        bytes_rem_next = bytes_dec;
                        phase_next     = PH_WR_LO;
                        scl_next       = 1'b0;
                        sda_next       = cmd.write_byte[7];
                    end
                end
                PH_RD_HI:
                begin
                    shift_next = {shift_reg[6:0], cmd.sda_in};
                    if (cnt_inc >= BITS_PER_BYTE)
                    begin
                        bit_cnt_next   = '0;
                        rvalid         = 1'b1;
                        rdata          = {shift_reg[6:0], cmd.sda_in};
                        bytes_rem_next = bytes_dec;
                        phase_next     = PH_RACK_LO;
                        scl_next       = 1'b0;
                        sda_next       = (bytes_dec == '0);
                    end
                    else
                    begin
                        bit_cnt_next = cnt_inc;
                        phase_next   = PH_RD_LO;
                        scl_next     = 1'b0;
                        sda_next     = 1'b1;
                    end
                end
                PH_RACK_LO:
                begin
                    phase_next = PH_RACK_HI;
                    scl_next   = 1'b1;
                end
                PH_RACK_HI:
                begin
                    phase_next = (bytes_rem_reg == '0) ? PH_STOP_LO : PH_RD_LO;
                    scl_next   = 1'b0;
                    sda_next   = (bytes_rem_reg != '0);
                end
                PH_STOP_LO:
                begin
                    phase_next = PH_STOP_HI;
                    scl_next   = 1'b1;
                    sda_next   = 1'b0;
                end
                PH_STOP_HI:
                begin
                    phase_next = PH_STOP_FREE;
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                end
                default:
                begin
                    done       = 1'b1;
                    phase_next = PH_IDLE;
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                end
            endcase
        end

        res.scl_out    = scl_next;
        res.sda_out    = sda_next;
        res.busy_res   = (phase_next != PH_IDLE);
        res.done_res   = done;
        res.status     = outcome_next;
        res.byte_taken = taken;
        res.read_data  = rdata;
        res.read_valid = rvalid;
    end

    ap_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        enable && res.done_res |=> phase_reg == PH_IDLE)
        else $error("done without return to idle");

    ap_taken_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        res.byte_taken |-> !read_dir_reg && !res.read_valid)
        else $error("byte taken outside a write");

    ap_idle_released: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> scl_reg && sda_reg)
        else $error("bus held while idle");

    ap_bit_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_cnt_reg < BITS_PER_BYTE)
        else $error("bit counter out of range");
endmodule

// ----- rtl/i2c_master_transaction_engine_unit.sv -----
`timescale 1ns / 1ps

// Channel  | Dir | Handshake     | Payload
// cmd      | in  | valid/ready   | op, device_address, byte_count, write_byte, sda_in
// rsp      | out | valid/ready   | scl_out, sda_out, busy_res, done_res, status,
//          |     |               | byte_taken, read_data, read_valid
// apb      | in  | psel/penable  | phase_ticks at address 0
//
// One transaction in per cycle, one out per cycle while rsp does not stall; each
// passes the command register, then the sequencer step into the response register.
// The sequencer state advances only when the command register moves on.
// rsp stalls hold the response register and back-pressure cmd through ready.
// rst_n clears the sequencer to idle with both lines released and
// phase_ticks to 5.

module i2c_master_transaction_engine_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    i2cm_cmd_if.sink                      cmd,
    i2cm_rsp_if.source                    rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [i2cm_pkg::PADDR_W-1:0]  paddr,
    input  logic [i2cm_pkg::PDATA_W-1:0]  pwdata,
    output logic [i2cm_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import i2cm_pkg::*;

    logic               s1_valid_reg;
    cmd_item_t          s1_item_reg;
    logic               out_valid_reg;
    rsp_item_t          out_item_reg;
    rsp_item_t          step_res;
    logic               advance;
    logic [PHASE_W-1:0] phase_ticks;

    assign advance   = !out_valid_reg || rsp.ready;
    assign cmd.ready = !s1_valid_reg || advance;

    i2cm_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .phase_ticks (phase_ticks)
    );

    i2cm_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .enable      (s1_valid_reg && advance),
        .cmd         (s1_item_reg),
        .phase_ticks (phase_ticks),
        .res         (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.ready)
            begin
                s1_valid_reg <= cmd.valid;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            s1_item_reg.op             <= cmd.op;
            s1_item_reg.device_address <= cmd.device_address;
            s1_item_reg.byte_count     <= cmd.byte_count;
            s1_item_reg.write_byte     <= cmd.write_byte;
            s1_item_reg.sda_in         <= cmd.sda_in;
        end
        if (s1_valid_reg && advance)
        begin
            out_item_reg <= step_res;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.scl_out    = out_item_reg.scl_out;
    assign rsp.sda_out    = out_item_reg.sda_out;
    assign rsp.busy_res   = out_item_reg.busy_res;
    assign rsp.done_res   = out_item_reg.done_res;
    assign rsp.status     = out_item_reg.status;
    assign rsp.byte_taken = out_item_reg.byte_taken;
    assign rsp.read_data  = out_item_reg.read_data;
    assign rsp.read_valid = out_item_reg.read_valid;

    ap_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid && cmd.ready |=> s1_valid_reg)
        else $error("accepted command lost");

    ap_stage_moves_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && advance |=> out_valid_reg)
        else $error("step result lost");

    ap_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg && $stable(s1_item_reg))
        else $error("stalled command changed");
endmodule

// ----- tb/i2c_master_transaction_engine_unit_tb.sv -----
`timescale 1ns / 1ps

module i2c_master_transaction_engine_unit_tb;

    import i2cm_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [PADDR_W-1:0] PHASE_TICKS_ADDR = PADDR_W'(4 * int'(REG_PHASE_TICKS));
    localparam int HOLD_OFF_CYCLES = 80;

    // Tick-accurate model of the bus sequencer; one expected bus state per command.
    class i2c_tick_tracker;
        logic [PHASE_W-1:0] phase_ticks;
        phase_t             phase;
        logic [3:0]         bit_cnt;
        logic [7:0]         shreg;
        logic [7:0]         remaining;
        logic [PHASE_W-1:0] timer;
        logic               rd_dir;
        logic [1:0]         outcome;
        logic               scl_drv;
        logic               sda_drv;
        int                 bytes_sent;
        int                 mismatches;
        rsp_item_t          pending_bus_states[$];

        function new();
            phase_ticks = PHASE_TICKS_RESET;
            phase       = PH_IDLE;
            bit_cnt     = '0;
            shreg       = '0;
            remaining   = '0;
            timer       = '0;
            rd_dir      = 1'b0;
            outcome     = STATUS_OK;
            scl_drv     = 1'b1;
            sda_drv     = 1'b1;
            bytes_sent  = 0;
            mismatches  = 0;
        endfunction

        function void move(phase_t nxt, logic scl, logic sda);
            phase   = nxt;
            scl_drv = scl;
            sda_drv = sda;
        endfunction

        function void accept_command(cmd_item_t c);
            rsp_item_t r;
            int        limit;
            r     = '0;
            limit = (phase_ticks == 0) ? 1 : int'(phase_ticks);
            if (phase == PH_IDLE)
            begin
                if (c.op == OP_WRITE || c.op == OP_READ)
                begin
                    rd_dir     = (c.op == OP_READ);
                    remaining  = c.byte_count;
                    shreg      = {c.device_address, rd_dir};
                    bit_cnt    = '0;
                    outcome    = STATUS_OK;
                    timer      = '0;
                    bytes_sent = 0;
                    move(PH_START, 1'b1, 1'b0);
                end
            end
            else if (int'(timer) + 1 < limit)
            begin
                timer = timer + 1'b1;
            end
            else
            begin
                timer = '0;
                case (phase)
                    PH_START:
                    begin
                        bit_cnt = '0;
                        move(PH_ADDR_LO, 1'b0, shreg[7]);
                    end
                    PH_ADDR_LO: move(PH_ADDR_HI, 1'b1, shreg[7]);
                    PH_WR_LO:   move(PH_WR_HI, 1'b1, shreg[7]);
                    PH_ADDR_HI, PH_WR_HI:
                    begin
                        bit_cnt = bit_cnt + 1'b1;
                        if (bit_cnt >= BITS_PER_BYTE)
                        begin
                            bit_cnt = '0;
                            if (phase == PH_ADDR_HI)
                                move(PH_AACK_LO, 1'b0, 1'b1);
                            else
                                move(PH_WACK_LO, 1'b0, 1'b1);
                        end
                        else
                        begin
                            shreg = shreg << 1;
                            if (phase == PH_ADDR_HI)
                                move(PH_ADDR_LO, 1'b0, shreg[7]);
                            else
                                move(PH_WR_LO, 1'b0, shreg[7]);
                        end
                    end
                    PH_AACK_LO: move(PH_AACK_HI, 1'b1, 1'b1);
                    PH_WACK_LO: move(PH_WACK_HI, 1'b1, 1'b1);
                    PH_RD_LO:   move(PH_RD_HI, 1'b1, 1'b1);
                    PH_AACK_HI, PH_WACK_HI:
                    begin
                        if (c.sda_in)
                        begin
                            outcome = (phase == PH_AACK_HI) ? STATUS_ADDR_NACK
                                                            : STATUS_DATA_NACK;
                            move(PH_STOP_LO, 1'b0, 1'b0);
                        end
                        else if (remaining == 0)
                        begin
                            move(PH_STOP_LO, 1'b0, 1'b0);
                        end
                        else if (rd_dir)
                        begin
                            shreg   = '0;
                            bit_cnt = '0;
                            move(PH_RD_LO, 1'b0, 1'b1);
                        end
                        else
                        begin
                            shreg        = c.write_byte;
                            r.byte_taken = 1'b1;
                            bit_cnt      = '0;
                            remaining    = remaining - 1'b1;
                            bytes_sent++;
                            move(PH_WR_LO, 1'b0, shreg[7]);
                        end
                    end
                    PH_RD_HI:
                    begin
                        shreg   = {shreg[6:0], c.sda_in};
                        bit_cnt = bit_cnt + 1'b1;
                        if (bit_cnt >= BITS_PER_BYTE)
                        begin
                            bit_cnt      = '0;
                            r.read_valid = 1'b1;
                            r.read_data  = shreg;
                            remaining    = remaining - 1'b1;
                            move(PH_RACK_LO, 1'b0, remaining == 0);
                        end
                        else
                        begin
                            move(PH_RD_LO, 1'b0, 1'b1);
                        end
                    end
                    PH_RACK_LO: move(PH_RACK_HI, 1'b1, sda_drv);
                    PH_RACK_HI:
                    begin
                        if (remaining == 0)
                            move(PH_STOP_LO, 1'b0, 1'b0);
                        else
                            move(PH_RD_LO, 1'b0, 1'b1);
                    end
                    PH_STOP_LO: move(PH_STOP_HI, 1'b1, 1'b0);
                    PH_STOP_HI: move(PH_STOP_FREE, 1'b1, 1'b1);
                    default:
                    begin
                        r.done_res = 1'b1;
                        move(PH_IDLE, 1'b1, 1'b1);
                    end
                endcase
            end
            r.scl_out  = scl_drv;
            r.sda_out  = sda_drv;
            r.busy_res = (phase != PH_IDLE);
            r.status   = outcome;
            pending_bus_states.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s: expected %0h, got %0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_bus_state(rsp_item_t got);
            rsp_item_t want;
            if (pending_bus_states.size() == 0)
            begin
                $error("unexpected transaction on rsp");
                mismatches++;
                return;
            end
            want = pending_bus_states.pop_front();
            compare_field("scl_out", want.scl_out, got.scl_out);
            compare_field("sda_out", want.sda_out, got.sda_out);
            compare_field("busy_res", want.busy_res, got.busy_res);
            compare_field("done_res", want.done_res, got.done_res);
            compare_field("status", want.status, got.status);
            compare_field("byte_taken", want.byte_taken, got.byte_taken);
            compare_field("read_data", want.read_data, got.read_data);
            compare_field("read_valid", want.read_valid, got.read_valid);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    i2cm_cmd_if cmd_bus ();
    i2cm_rsp_if rsp_bus ();

    i2c_tick_tracker tracker;
    int send_idle;
    int recv_idle;
    int items_sent;
    bit hold_request;

    i2c_master_transaction_engine_unit i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_bus),
        .rsp     (rsp_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("i2c_master_transaction_engine_unit_tb: FAIL");
        $finish;
    end

    initial
    begin
        rsp_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                rsp_bus.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_request = 1'b0;
            end
            else
            begin
                rsp_bus.ready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    always @(posedge clk)
    begin
        rsp_item_t got;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            got.scl_out    = rsp_bus.scl_out;
            got.sda_out    = rsp_bus.sda_out;
            got.busy_res   = rsp_bus.busy_res;
            got.done_res   = rsp_bus.done_res;
            got.status     = rsp_bus.status;
            got.byte_taken = rsp_bus.byte_taken;
            got.read_data  = rsp_bus.read_data;
            got.read_valid = rsp_bus.read_valid;
            tracker.check_bus_state(got);
        end
    end

    function automatic cmd_item_t random_cmd();
        cmd_item_t c;
        c.op             = 2'($urandom_range(3));
        c.device_address = 7'($urandom_range(127));
        c.byte_count     = 8'($urandom_range(255));
        c.write_byte     = 8'($urandom_range(255));
        c.sda_in         = 1'($urandom_range(1));
        return c;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(cmd_item_t c);
        while ($urandom_range(99) < send_idle)
        begin
            cmd_bus.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_bus.valid          <= 1'b1;
        cmd_bus.op             <= c.op;
        cmd_bus.device_address <= c.device_address;
        cmd_bus.byte_count     <= c.byte_count;
        cmd_bus.write_byte     <= c.write_byte;
        cmd_bus.sda_in         <= c.sda_in;
        do @(posedge clk); while (!cmd_bus.ready);
        tracker.accept_command(c);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_idle_tick();
        cmd_item_t c;
        c    = random_cmd();
        c.op = ($urandom_range(1) == 1) ? OP_UNUSED : OP_TICK;
        send_item(c);
    endtask

    // nack_at: data byte (1-based) that the target refuses; 0 for none.
    task automatic run_transaction(logic [1:0] op, logic [6:0] addr, logic [7:0] count,
                                   bit addr_ack, int nack_at, bit noise);
        cmd_item_t c;
        c                = random_cmd();
        c.op             = op;
        c.device_address = addr;
        c.byte_count     = count;
        send_item(c);
        while (tracker.phase != PH_IDLE)
        begin
            c    = random_cmd();
            c.op = OP_TICK;
            if (noise && $urandom_range(99) < 4)
                c.op = 2'($urandom_range(3, 1));
            if (tracker.phase == PH_AACK_HI)
                c.sda_in = !addr_ack;
            else if (tracker.phase == PH_WACK_HI)
                c.sda_in = (nack_at != 0 && tracker.bytes_sent == nack_at);
            send_item(c);
        end
    endtask

    task automatic wait_drain();
        cmd_bus.valid <= 1'b0;
        while (tracker.pending_bus_states.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_phase_ticks(logic [PHASE_W-1:0] value);
        wait_drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PHASE_TICKS_ADDR;
        pwdata  <= PDATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        tracker.phase_ticks = value;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        tracker.compare_field("phase_ticks", PDATA_W'(value), prdata);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_random(int quota);
        int   stop_at;
        int   nack_at;
        logic [7:0] count;
        bit   is_read;
        stop_at = items_sent + quota;
        while (items_sent < stop_at)
        begin
            is_read = $urandom_range(1);
            nack_at = 0;
            if (is_read)
            begin
                count = 8'($urandom_range(3));
            end
            else if ($urandom_range(99) < 70)
            begin
                count   = 8'($urandom_range(255));
                nack_at = $urandom_range(4, 1);
            end
            else
            begin
                count = 8'($urandom_range(4));
            end
            run_transaction(is_read ? OP_READ : OP_WRITE, 7'($urandom_range(127)), count,
                            $urandom_range(99) < 85, nack_at, 1'b1);
            repeat ($urandom_range(2)) send_idle_tick();
        end
    endtask

    initial
    begin
        cmd_bus.valid          = 1'b0;
        cmd_bus.op             = OP_TICK;
        cmd_bus.device_address = '0;
        cmd_bus.byte_count     = '0;
        cmd_bus.write_byte     = '0;
        cmd_bus.sda_in         = 1'b1;
        psel                   = 1'b0;
        penable                = 1'b0;
        pwrite                 = 1'b0;
        paddr                  = '0;
        pwdata                 = '0;
        hold_request           = 1'b0;
        items_sent             = 0;
        send_idle              = 30;
        recv_idle              = 70;
        tracker                = new();
        rst_n                  = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed
        run_transaction(OP_WRITE, 7'h00, 8'd1, 1'b1, 0, 1'b0);
        send_idle_tick();
        send_idle_tick();
        write_phase_ticks('0);
        run_transaction(OP_WRITE, 7'h7F, 8'd0, 1'b1, 0, 1'b0);
        run_transaction(OP_READ, 7'h55, 8'd2, 1'b1, 0, 1'b1);
        run_transaction(OP_WRITE, 7'h2A, 8'd255, 1'b1, 2, 1'b1);
        run_transaction(OP_READ, 7'h7F, 8'd3, 1'b0, 0, 1'b1);

        // random, sender idling lightly, receiver heavily
        write_phase_ticks(10'd1);
        run_random(60);

        send_idle = 70;
        recv_idle = 30;
        write_phase_ticks(10'($urandom_range(3, 2)));
        run_random(10);
        wait_drain();
        run_random(10);

        send_idle = 0;
        recv_idle = 0;
        write_phase_ticks(10'd1);
        hold_request = 1'b1;
        run_random(60);

        write_phase_ticks(10'd1023);
        send_idle_tick();
        send_idle_tick();

        wait_drain();
        repeat (10) @(posedge clk);
        if (tracker.mismatches == 0)
            $display("i2c_master_transaction_engine_unit_tb: PASS");
        else
            $display("i2c_master_transaction_engine_unit_tb: FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/i2cm_pkg.sv
rtl/i2cm_cmd_if.sv
rtl/i2cm_rsp_if.sv
rtl/i2cm_regs.sv
rtl/i2cm_seq.sv
rtl/i2c_master_transaction_engine_unit.sv
tb/i2c_master_transaction_engine_unit_tb.sv
